[rtl/core/cesm_pkg.sv]
`timescale 1ns / 1ps

package cesm_pkg;

   localparam logic [7:0] FRAME_OPEN  = 8'hFC;
   localparam logic [7:0] FRAME_CLOSE = 8'hFD;
   localparam logic [7:0] SPEED_LIMIT = 8'd150;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [2:0] REG_BRAKE_TICKS   = 3'd0;
   localparam logic [2:0] REG_PAUSE_TICKS   = 3'd1;
   localparam logic [2:0] REG_REVERSE_TICKS = 3'd2;
   localparam logic [2:0] REG_TURN_TICKS    = 3'd3;
   localparam logic [2:0] REG_POLL_TICKS    = 3'd4;
   localparam logic [2:0] REG_CRUISE_SPEED  = 3'd5;
   localparam logic [2:0] REG_TURN_SPEED    = 3'd6;
   localparam logic [2:0] REG_BRAKE_SPEED   = 3'd7;

   localparam logic [15:0] BRAKE_TICKS_RST   = 16'd100;
   localparam logic [15:0] PAUSE_TICKS_RST   = 16'd100;
   localparam logic [15:0] REVERSE_TICKS_RST = 16'd400;
   localparam logic [15:0] TURN_TICKS_RST    = 16'd900;
   localparam logic [15:0] POLL_TICKS_RST    = 16'd20;
   localparam logic [7:0]  CRUISE_SPEED_RST  = 8'd50;
   localparam logic [7:0]  TURN_SPEED_RST    = 8'd60;
   localparam logic [7:0]  BRAKE_SPEED_RST   = 8'd80;

   typedef struct packed {
      logic cliff_left;
      logic cliff_right;
   } cesm_req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } cesm_rsp_type;

   typedef struct packed {
      logic [15:0] brake_ticks;
      logic [15:0] pause_ticks;
      logic [15:0] reverse_ticks;
      logic [15:0] turn_ticks;
      logic [15:0] poll_ticks;
      logic [7:0]  cruise_speed;
      logic [7:0]  turn_speed;
      logic [7:0]  brake_speed;
   } cesm_cfg_type;

   typedef struct packed {
      logic       dir_a;
      logic [7:0] speed_a;
      logic       dir_b;
      logic [7:0] speed_b;
   } cesm_cmd_type;

   function automatic logic [7:0] clamp_speed(input logic [7:0] s);
      return (s > SPEED_LIMIT) ? SPEED_LIMIT : s;
   endfunction

   // a wheel only reports backward when it actually moves
   function automatic cesm_cmd_type make_cmd(input logic back_a, input logic [7:0] sp_a,
                                             input logic back_b, input logic [7:0] sp_b);
      cesm_cmd_type c;
      c.dir_a   = back_a && (sp_a != 8'd0);
      c.speed_a = clamp_speed(sp_a);
      c.dir_b   = back_b && (sp_b != 8'd0);
      c.speed_b = clamp_speed(sp_b);
      return c;
   endfunction

endpackage

[rtl/core/cesm_front.sv]
`timescale 1ns / 1ps

module cesm_front #(
   parameter int TICK_COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick_take,
   input  cesm_pkg::cesm_req_type tick,
   input  cesm_pkg::cesm_cfg_type cfg,
   output logic                   cmd_push,
   output cesm_pkg::cesm_cmd_type cmd
);

   typedef enum logic [5:0] {
      PH_SAMPLE  = 6'b000001,
      PH_BRAKE   = 6'b000010,
      PH_PAUSE   = 6'b000100,
      PH_REVERSE = 6'b001000,
      PH_TURN    = 6'b010000,
      PH_POLL    = 6'b100000
   } phase_type;

   localparam logic [32:0] COUNT_MAX = (33'(1) << TICK_COUNT_BITS) - 33'(1);

   function automatic logic [TICK_COUNT_BITS-1:0] load_count(input logic [15:0] v);
      logic [32:0] c;
      c = {17'd0, v};
      if (c == 33'd0) c = 33'd1;
      if (c > COUNT_MAX) c = COUNT_MAX;
      return c[TICK_COUNT_BITS-1:0];
   endfunction

   phase_type                  phase_ff, phase_in;
   logic [TICK_COUNT_BITS-1:0] countdown_ff, countdown_in;
   logic                       side_ff, side_in;
   logic                       do_sample;

   always_comb begin
      phase_in     = phase_ff;
      countdown_in = countdown_ff;
      side_in      = side_ff;
      cmd_push     = 1'b0;
      cmd          = '0;
      do_sample    = 1'b0;
      if (tick_take) begin
         unique case (phase_ff) inside
            PH_BRAKE, PH_PAUSE, PH_REVERSE, PH_TURN, PH_POLL: begin
               if (countdown_ff > TICK_COUNT_BITS'(1)) begin
                  countdown_in = countdown_ff - TICK_COUNT_BITS'(1);
               end else begin
                  unique case (phase_ff)
                     PH_BRAKE: begin
                        phase_in     = PH_PAUSE;
                        countdown_in = load_count(cfg.pause_ticks);
                        cmd_push     = 1'b1;
                        cmd          = cesm_pkg::make_cmd(1'b0, 8'd0, 1'b0, 8'd0);
                     end
                     PH_PAUSE: begin
                        phase_in     = PH_REVERSE;
                        countdown_in = load_count(cfg.reverse_ticks);
                        cmd_push     = 1'b1;
                        cmd          = cesm_pkg::make_cmd(1'b1, cfg.cruise_speed,
                                                          1'b1, cfg.cruise_speed);
                     end
                     PH_REVERSE: begin
                        phase_in     = PH_TURN;
                        countdown_in = load_count(cfg.turn_ticks);
                        cmd_push     = 1'b1;
                        cmd          = cesm_pkg::make_cmd(side_ff, cfg.turn_speed,
                                                          !side_ff, cfg.turn_speed);
                     end
                     PH_TURN: begin
                        phase_in     = PH_POLL;
                        countdown_in = load_count(cfg.poll_ticks);
                     end
                     default: begin
                        do_sample = 1'b1;
                     end
                  endcase
               end
            end
            default: begin
               do_sample = 1'b1;
            end
         endcase

         if (do_sample) begin
            cmd_push = 1'b1;
            if (tick.cliff_left || tick.cliff_right) begin
               side_in      = !tick.cliff_left;
               phase_in     = PH_BRAKE;
               countdown_in = load_count(cfg.brake_ticks);
               cmd          = cesm_pkg::make_cmd(1'b1, cfg.brake_speed,
                                                 1'b1, cfg.brake_speed);
            end else begin
               phase_in     = PH_POLL;
               countdown_in = load_count(cfg.poll_ticks);
               cmd          = cesm_pkg::make_cmd(1'b0, cfg.cruise_speed,
                                                 1'b0, cfg.cruise_speed);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SAMPLE;
         countdown_ff <= '0;
         side_ff      <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         countdown_ff <= countdown_in;
         side_ff      <= side_in;
      end
   end

endmodule

[rtl/core/cesm_fifo.sv]
`timescale 1ns / 1ps

module cesm_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cesm_pkg::cesm_cmd_type push_data,
   input  logic                   pop,
   output cesm_pkg::cesm_cmd_type pop_data,
   output logic                   full,
   output logic                   not_empty
);

   cesm_pkg::cesm_cmd_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/cesm_back.sv]
`timescale 1ns / 1ps

module cesm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_avail,
   input  cesm_pkg::cesm_cmd_type cmd_data,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cesm_pkg::cesm_rsp_type rsp_data
);

   localparam logic [2:0] SLOT_OPEN    = 3'd0;
   localparam logic [2:0] SLOT_DIR_A   = 3'd1;
   localparam logic [2:0] SLOT_SPEED_A = 3'd2;
   localparam logic [2:0] SLOT_DIR_B   = 3'd3;
   localparam logic [2:0] SLOT_SPEED_B = 3'd4;
   localparam logic [2:0] SLOT_CLOSE   = 3'd5;

   cesm_pkg::cesm_cmd_type cur_ff, cur_in;
   logic                   busy_ff, busy_in;
   logic [2:0]             slot_ff, slot_in;
   logic                   out_valid_ff, out_valid_in;
   cesm_pkg::cesm_rsp_type out_ff, out_in;
   logic                   advance;
   logic [7:0]             byte_sel;

   assign advance   = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      case (slot_ff)
         SLOT_OPEN:    byte_sel = cesm_pkg::FRAME_OPEN;
         SLOT_DIR_A:   byte_sel = {7'd0, cur_ff.dir_a};
         SLOT_SPEED_A: byte_sel = cur_ff.speed_a;
         SLOT_DIR_B:   byte_sel = {7'd0, cur_ff.dir_b};
         SLOT_SPEED_B: byte_sel = cur_ff.speed_b;
         default:      byte_sel = cesm_pkg::FRAME_CLOSE;
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      if (advance) begin
         out_valid_in = busy_ff;
         if (busy_ff) begin
            out_in.frame_byte = byte_sel;
            out_in.frame_last = (slot_ff == SLOT_CLOSE);
            slot_in           = slot_ff + 3'd1;
            if (slot_ff == SLOT_CLOSE) begin
               busy_in = 1'b0;
            end
         end
      end
      // refill the frame register as soon as the current frame is out
      if (!busy_in && cmd_avail) begin
         cmd_pop = 1'b1;
         cur_in  = cmd_data;
         busy_in = 1'b1;
         slot_in = SLOT_OPEN;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= SLOT_OPEN;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[rtl/core/cliff_escape_motor_sequencer_top.sv]
`timescale 1ns / 1ps

// Cliff escape motor sequencer. Each req transaction is one timer tick with the
// left and right cliff levels; ticks that start or end a phase, except the end of
// the turn phase, produce one motor command frame of six rsp transactions (0xFC,
// dir A, speed A, dir B, speed B, 0xFD, frame_last on the last byte). A tick is
// taken while req_ready is high; the front sequencer feeds a two-entry queue and
// the frame serializer drains one byte per cycle while rsp_ready is high; req_ready
// drops only while the queue holds two unsent frames. Phase durations and speeds
// live in the csr registers at byte address 4*index; write them while idle.

module cliff_escape_motor_sequencer_top #(
   parameter int TICK_COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  cesm_pkg::cesm_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output cesm_pkg::cesm_rsp_type                rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [cesm_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [cesm_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [cesm_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   cesm_pkg::cesm_cfg_type cfg_ff, cfg_in;
   logic [2:0]             reg_idx;
   logic                   csr_wr;
   logic                   tick_take;
   logic                   cmd_push;
   cesm_pkg::cesm_cmd_type cmd_front;
   cesm_pkg::cesm_cmd_type cmd_back;
   logic                   q_full;
   logic                   q_avail;
   logic                   q_pop;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[cesm_pkg::CSR_ADDR_BITS-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            cesm_pkg::REG_BRAKE_TICKS:   cfg_in.brake_ticks   = csr_pwdata[15:0];
            cesm_pkg::REG_PAUSE_TICKS:   cfg_in.pause_ticks   = csr_pwdata[15:0];
            cesm_pkg::REG_REVERSE_TICKS: cfg_in.reverse_ticks = csr_pwdata[15:0];
            cesm_pkg::REG_TURN_TICKS:    cfg_in.turn_ticks    = csr_pwdata[15:0];
            cesm_pkg::REG_POLL_TICKS:    cfg_in.poll_ticks    = csr_pwdata[15:0];
            cesm_pkg::REG_CRUISE_SPEED:  cfg_in.cruise_speed  = csr_pwdata[7:0];
            cesm_pkg::REG_TURN_SPEED:    cfg_in.turn_speed    = csr_pwdata[7:0];
            cesm_pkg::REG_BRAKE_SPEED:   cfg_in.brake_speed   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         cesm_pkg::REG_BRAKE_TICKS:   csr_prdata = {16'd0, cfg_ff.brake_ticks};
         cesm_pkg::REG_PAUSE_TICKS:   csr_prdata = {16'd0, cfg_ff.pause_ticks};
         cesm_pkg::REG_REVERSE_TICKS: csr_prdata = {16'd0, cfg_ff.reverse_ticks};
         cesm_pkg::REG_TURN_TICKS:    csr_prdata = {16'd0, cfg_ff.turn_ticks};
         cesm_pkg::REG_POLL_TICKS:    csr_prdata = {16'd0, cfg_ff.poll_ticks};
         cesm_pkg::REG_CRUISE_SPEED:  csr_prdata = {24'd0, cfg_ff.cruise_speed};
         cesm_pkg::REG_TURN_SPEED:    csr_prdata = {24'd0, cfg_ff.turn_speed};
         default:                     csr_prdata = {24'd0, cfg_ff.brake_speed};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brake_ticks   <= cesm_pkg::BRAKE_TICKS_RST;
         cfg_ff.pause_ticks   <= cesm_pkg::PAUSE_TICKS_RST;
         cfg_ff.reverse_ticks <= cesm_pkg::REVERSE_TICKS_RST;
         cfg_ff.turn_ticks    <= cesm_pkg::TURN_TICKS_RST;
         cfg_ff.poll_ticks    <= cesm_pkg::POLL_TICKS_RST;
         cfg_ff.cruise_speed  <= cesm_pkg::CRUISE_SPEED_RST;
         cfg_ff.turn_speed    <= cesm_pkg::TURN_SPEED_RST;
         cfg_ff.brake_speed   <= cesm_pkg::BRAKE_SPEED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !q_full;
   assign tick_take = req_valid && req_ready;

   cesm_front #(
      .TICK_COUNT_BITS (TICK_COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .tick_take (tick_take),
      .tick      (req_data),
      .cfg       (cfg_ff),
      .cmd_push  (cmd_push),
      .cmd       (cmd_front)
   );

   cesm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_front),
      .pop       (q_pop),
      .pop_data  (cmd_back),
      .full      (q_full),
      .not_empty (q_avail)
   );

   cesm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_avail (q_avail),
      .cmd_data  (cmd_back),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/cesm_checker.sv]
`timescale 1ns / 1ps

module cesm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input cesm_pkg::cesm_rsp_type rsp_data,
   input logic                   csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction dropped or changed while stalled");

   a_last_is_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_last |-> rsp_data.frame_byte == cesm_pkg::FRAME_CLOSE)
      else $error("frame_last on a byte other than the close byte");

   a_open_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_byte == cesm_pkg::FRAME_OPEN |-> !rsp_data.frame_last)
      else $error("open byte flagged as last");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr_pready low");

endmodule

bind cliff_escape_motor_sequencer_top cesm_checker u_cesm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);

[sim/cliff_escape_motor_sequencer_top_tb.sv]
`timescale 1ns / 1ps

module cliff_escape_motor_sequencer_top_tb;

   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_TICKS  = 60;
   localparam int LONG_TICKS    = 40;

   // left cliff, right cliff
   localparam logic [1:0] DIRECTED_TICKS [17] = '{
      2'b00, 2'b10, 2'b00, 2'b00, 2'b00, 2'b00,
      2'b01, 2'b00, 2'b00, 2'b00, 2'b00,
      2'b11, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00
   };

   typedef enum logic [5:0] {
      PH_SAMPLE  = 6'b000001,
      PH_BRAKE   = 6'b000010,
      PH_PAUSE   = 6'b000100,
      PH_REVERSE = 6'b001000,
      PH_TURN    = 6'b010000,
      PH_POLL    = 6'b100000
   } seq_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   cesm_pkg::cesm_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   cesm_pkg::cesm_rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [cesm_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [cesm_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [cesm_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   cesm_pkg::cesm_req_type pending_ticks[$];
   cesm_pkg::cesm_rsp_type expected_bytes[$];
   int ticks_sent = 0;
   int ticks_taken = 0;

   cesm_pkg::cesm_cfg_type model_cfg = '{
      brake_ticks: cesm_pkg::BRAKE_TICKS_RST, pause_ticks: cesm_pkg::PAUSE_TICKS_RST,
      reverse_ticks: cesm_pkg::REVERSE_TICKS_RST, turn_ticks: cesm_pkg::TURN_TICKS_RST,
      poll_ticks: cesm_pkg::POLL_TICKS_RST, cruise_speed: cesm_pkg::CRUISE_SPEED_RST,
      turn_speed: cesm_pkg::TURN_SPEED_RST, brake_speed: cesm_pkg::BRAKE_SPEED_RST
   };
   seq_phase_type seq_phase = PH_SAMPLE;
   logic [15:0] count_left = '0;
   logic turn_left = 1'b0;

   bit calm = 1'b0;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   cliff_escape_motor_sequencer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   function automatic logic [15:0] ticks_or_one(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   function automatic void push_frame(input logic back_a, input logic [7:0] sp_a,
                                      input logic back_b, input logic [7:0] sp_b);
      logic [7:0] frame [6];
      cesm_pkg::cesm_rsp_type r;
      frame[0] = cesm_pkg::FRAME_OPEN;
      frame[1] = {7'd0, back_a && sp_a != 8'd0};
      frame[2] = (sp_a > cesm_pkg::SPEED_LIMIT) ? cesm_pkg::SPEED_LIMIT : sp_a;
      frame[3] = {7'd0, back_b && sp_b != 8'd0};
      frame[4] = (sp_b > cesm_pkg::SPEED_LIMIT) ? cesm_pkg::SPEED_LIMIT : sp_b;
      frame[5] = cesm_pkg::FRAME_CLOSE;
      for (int k = 0; k < 6; k++) begin
         r.frame_byte = frame[k];
         r.frame_last = (k == 5);
         expected_bytes.push_back(r);
      end
   endfunction

   function automatic void advance_sequencer(input cesm_pkg::cesm_req_type t);
      if (seq_phase != PH_SAMPLE && count_left > 16'd1) begin
         count_left = count_left - 16'd1;
      end else begin
         case (seq_phase)
            PH_BRAKE: begin
               seq_phase = PH_PAUSE;
               count_left = ticks_or_one(model_cfg.pause_ticks);
               push_frame(1'b0, 8'd0, 1'b0, 8'd0);
            end
            PH_PAUSE: begin
               seq_phase = PH_REVERSE;
               count_left = ticks_or_one(model_cfg.reverse_ticks);
               push_frame(1'b1, model_cfg.cruise_speed, 1'b1, model_cfg.cruise_speed);
            end
            PH_REVERSE: begin
               seq_phase = PH_TURN;
               count_left = ticks_or_one(model_cfg.turn_ticks);
               push_frame(turn_left, model_cfg.turn_speed, !turn_left, model_cfg.turn_speed);
            end
            PH_TURN: begin
               seq_phase = PH_POLL;
               count_left = ticks_or_one(model_cfg.poll_ticks);
            end
            default: begin
               if (t.cliff_left || t.cliff_right) begin
                  turn_left = !t.cliff_left;
                  seq_phase = PH_BRAKE;
                  count_left = ticks_or_one(model_cfg.brake_ticks);
                  push_frame(1'b1, model_cfg.brake_speed, 1'b1, model_cfg.brake_speed);
               end else begin
                  seq_phase = PH_POLL;
                  count_left = ticks_or_one(model_cfg.poll_ticks);
                  push_frame(1'b0, model_cfg.cruise_speed, 1'b0, model_cfg.cruise_speed);
               end
            end
         endcase
      end
   endfunction

   function automatic cesm_pkg::cesm_cfg_type random_setting();
      cesm_pkg::cesm_cfg_type c;
      c.brake_ticks   = 16'($urandom_range(5));
      c.pause_ticks   = 16'($urandom_range(5));
      c.reverse_ticks = 16'($urandom_range(5));
      c.turn_ticks    = 16'($urandom_range(5));
      c.poll_ticks    = 16'($urandom_range(5));
      c.cruise_speed  = 8'($urandom_range(255));
      c.turn_speed    = 8'($urandom_range(255));
      c.brake_speed   = 8'($urandom_range(255));
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t: %s", $time, msg);
   endtask

   task automatic queue_tick(input cesm_pkg::cesm_req_type t);
      pending_ticks.push_back(t);
      ticks_sent++;
   endtask

   task automatic queue_random_tick();
      cesm_pkg::cesm_req_type t;
      t.cliff_left  = ($urandom_range(99) < 25);
      t.cliff_right = ($urandom_range(99) < 25);
      queue_tick(t);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         cesm_pkg::REG_BRAKE_TICKS:   model_cfg.brake_ticks = value[15:0];
         cesm_pkg::REG_PAUSE_TICKS:   model_cfg.pause_ticks = value[15:0];
         cesm_pkg::REG_REVERSE_TICKS: model_cfg.reverse_ticks = value[15:0];
         cesm_pkg::REG_TURN_TICKS:    model_cfg.turn_ticks = value[15:0];
         cesm_pkg::REG_POLL_TICKS:    model_cfg.poll_ticks = value[15:0];
         cesm_pkg::REG_CRUISE_SPEED:  model_cfg.cruise_speed = value[7:0];
         cesm_pkg::REG_TURN_SPEED:    model_cfg.turn_speed = value[7:0];
         cesm_pkg::REG_BRAKE_SPEED:   model_cfg.brake_speed = value[7:0];
         default: ;
      endcase
   endtask

   // upper bits carry junk that the block must drop
   task automatic program_all(input cesm_pkg::cesm_cfg_type c, input logic [31:0] junk);
      write_reg(cesm_pkg::REG_BRAKE_TICKS,   {junk[31:16], c.brake_ticks});
      write_reg(cesm_pkg::REG_PAUSE_TICKS,   {junk[31:16], c.pause_ticks});
      write_reg(cesm_pkg::REG_REVERSE_TICKS, {junk[31:16], c.reverse_ticks});
      write_reg(cesm_pkg::REG_TURN_TICKS,    {junk[31:16], c.turn_ticks});
      write_reg(cesm_pkg::REG_POLL_TICKS,    {junk[31:16], c.poll_ticks});
      write_reg(cesm_pkg::REG_CRUISE_SPEED,  {junk[31:8], c.cruise_speed});
      write_reg(cesm_pkg::REG_TURN_SPEED,    {junk[31:8], c.turn_speed});
      write_reg(cesm_pkg::REG_BRAKE_SPEED,   {junk[31:8], c.brake_speed});
   endtask

   task automatic wait_drained();
      while (ticks_taken != ticks_sent || expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            advance_sequencer(req_data);
            ticks_taken++;
         end
         if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
            req_valid <= 1'b1;
            req_data <= pending_ticks.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // frame monitor and receiver
   always @(posedge clock) begin
      cesm_pkg::cesm_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("frame byte 0x%02h with none pending",
                                         rsp_data.frame_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.frame_byte !== want.frame_byte) begin
                  report_mismatch($sformatf("frame_byte 0x%02h, expected 0x%02h",
                                            rsp_data.frame_byte, want.frame_byte));
               end
               if (rsp_data.frame_last !== want.frame_last) begin
                  report_mismatch($sformatf("frame_last %b, expected %b",
                                            rsp_data.frame_last, want.frame_last));
               end
            end
         end
         if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 35);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("[cliff_escape_motor_sequencer_top] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      cesm_pkg::cesm_cfg_type c;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      repeat (40) queue_random_tick();
      wait_drained();

      // zero durations, zero and clamped speeds, every escape side
      c = '{brake_ticks: 16'd0, pause_ticks: 16'd0, reverse_ticks: 16'd0,
            turn_ticks: 16'd0, poll_ticks: 16'd0, cruise_speed: 8'd0,
            turn_speed: 8'd255, brake_speed: 8'd151};
      program_all(c, 32'd0);
      foreach (DIRECTED_TICKS[i]) queue_tick(cesm_pkg::cesm_req_type'(DIRECTED_TICKS[i]));
      wait_drained();

      // backpressure: receiver holds off while ticks keep coming
      c = '{brake_ticks: 16'd1, pause_ticks: 16'd1, reverse_ticks: 16'd1,
            turn_ticks: 16'd1, poll_ticks: 16'd1, cruise_speed: 8'd150,
            turn_speed: 8'd149, brake_speed: 8'd255};
      program_all(c, 32'hFFFF_FFFF);
      calm = 1'b1;
      repeat (40) queue_random_tick();
      hold_seq++;
      wait_drained();

      for (int s = 0; s < 6; s++) begin
         program_all(random_setting(), $urandom);
         calm = (s == 3);
         repeat (RANDOM_TICKS) queue_random_tick();
         wait_drained();
      end

      // full-range countdowns
      c = '{brake_ticks: 16'hFFFF, pause_ticks: 16'd1, reverse_ticks: 16'd1,
            turn_ticks: 16'd2, poll_ticks: 16'hFFFF, cruise_speed: 8'd255,
            turn_speed: 8'd255, brake_speed: 8'd255};
      program_all(c, 32'd0);
      calm = 1'b1;
      queue_tick(cesm_pkg::cesm_req_type'(2'b01));
      repeat (LONG_TICKS) queue_random_tick();
      wait_drained();

      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("[cliff_escape_motor_sequencer_top] OK");
      end else begin
         $display("[cliff_escape_motor_sequencer_top] ERROR");
      end
      $finish;
   end

endmodule
